FILE: sv/assert_macros.svh
// Assertion macros used by the top level of the thermistor temperature block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked assertion that is switched off while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// Clocked assertion that is also checked during reset.
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

FILE: sv/ntcsh_pkg.sv
// Package with the types, constants and log table of the thermistor temperature block.
package ntcsh_pkg;

    // Field and register widths.
    localparam int SAMPLE_W   = 22;
    localparam int VREF_W     = 22;
    localparam int BAL_W      = 20;
    localparam int TOL_W      = 16;
    localparam int COEF_W     = 40;
    localparam int TEMP_W     = 21;

    // Log table geometry; the depth is a power of two.
    localparam int LOG_TABLE_DEPTH = 256;
    localparam int LOG_IDX_W       = $clog2(LOG_TABLE_DEPTH);
    localparam int LOG_ENT_W       = 25;
    localparam int LOG_FRAC_W      = 24;

    // Datapath widths.
    localparam int NUM_W      = BAL_W + VREF_W;
    localparam int R_W        = 48;
    localparam int R_FRAC_W   = 16;
    localparam int LG_W       = 30;
    localparam int ABS_W      = 29;
    localparam int LN_PROD_W  = 61;
    localparam int SQ_W       = 58;
    localparam int L3_W       = 39;
    localparam int TB_W       = 45;
    localparam int TC_W       = 55;
    localparam int S_W        = 58;
    localparam int D_W        = 57;
    localparam int TQ_W       = 21;
    localparam int RES_W      = 24;

    // Arithmetic constants.
    localparam logic [31:0]              LN2_Q32   = 32'd2977044472;
    localparam logic [D_W-1:0]           MK_HEAD   = D_W'(1000) << (48 - TQ_W);
    localparam logic signed [RES_W-1:0]  OFFSET_MK = 24'sd273150;
    localparam logic signed [TEMP_W-1:0] OUT_LOW   = -21'sd274000;
    localparam logic signed [TEMP_W-1:0] OUT_HIGH  = 21'sd1000000;
    localparam logic [R_W-1:0]           R_MAX     = '1;

    // Configuration port.
    localparam int APB_ADDR_W = 6;
    localparam int APB_DATA_W = 64;

    typedef enum logic [2:0] {
        REG_VREF   = 3'd0,
        REG_BAL    = 3'd1,
        REG_TOL    = 3'd2,
        REG_COEF_A = 3'd3,
        REG_COEF_B = 3'd4,
        REG_COEF_C = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [VREF_W-1:0] vref;
        logic [BAL_W-1:0]  bal;
        logic [TOL_W-1:0]  tol;
        logic [COEF_W-1:0] coef_a;
        logic [COEF_W-1:0] coef_b;
        logic [COEF_W-1:0] coef_c;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        vref:   22'd2500000,
        bal:    20'd10000,
        tol:    16'd100,
        coef_a: 40'd317826907003,
        coef_b: 40'd65900328922,
        coef_c: 40'd24678065
    };

    typedef logic [LOG_TABLE_DEPTH:0][LOG_ENT_W-1:0] t_log_tab;

    // log2(1 + i/depth) in Q0.24 by repeated truncating squaring.
    function automatic t_log_tab build_log_tab();
        t_log_tab              tab;
        logic [63:0]           x;
        logic [LOG_FRAC_W-1:0] r;
        tab = '0;
        for (int i = 0; i < LOG_TABLE_DEPTH; i++) begin
            x = (64'd1 << 30) + ((64'(i) << 30) / LOG_TABLE_DEPTH);
            r = '0;
            for (int k = LOG_FRAC_W - 1; k >= 0; k--) begin
                x = (x * x) >> 30;
                if (x >= (64'd1 << 31)) begin
                    x    = x >> 1;
                    r[k] = 1'b1;
                end
            end
            tab[i] = {1'b0, r};
        end
        tab[LOG_TABLE_DEPTH] = LOG_ENT_W'(1) << LOG_FRAC_W;
        return tab;
    endfunction

    localparam t_log_tab LOG_TAB = build_log_tab();

endpackage

FILE: sv/ntcsh_ifs.sv
// Valid/ready channel interfaces for the sample input and the temperature output.
interface ntcsh_sample_if import ntcsh_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample_uv;

    modport source(output valid, output sample_uv, input ready);
    modport sink(input valid, input sample_uv, output ready);
endinterface

interface ntcsh_temp_if import ntcsh_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [TEMP_W-1:0] temp_milli_c;

    modport source(output valid, output temp_milli_c, input ready);
    modport sink(input valid, input temp_milli_c, output ready);
endinterface

FILE: sv/ntcsh_resist.sv
// Clamp and pipelined divider that turn a divider voltage into thermistor resistance.
module ntcsh_resist import ntcsh_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [SAMPLE_W-1:0] i_sample,
    input  t_cfg                i_cfg,
    output logic                o_valid,
    output logic [R_W-1:0]      o_r
);

    localparam int DIV_N = R_W;
    localparam int LOW_W = NUM_W - R_FRAC_W - (R_W - 32);

    // Sample register.
    logic                r_a_v;
    logic [SAMPLE_W-1:0] r_a_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (i_en) begin
            r_a_v <= i_valid;
        end
        if (i_en) begin
            r_a_s <= i_sample;
        end
    end

    // Clamp: the low bound first, then the high bound.
    logic signed [23:0] n_tol, n_hi, n_v1, n_v2, n_num;
    logic               r_b_v, r_b_sat, r_b_one;
    logic [VREF_W-1:0]  r_b_vc, r_b_num;

    always_comb begin
        n_tol = $signed({8'b0, i_cfg.tol});
        n_hi  = $signed({2'b0, i_cfg.vref}) - n_tol;
        n_v1  = ($signed({2'b0, r_a_s}) <= n_tol) ? n_tol : $signed({2'b0, r_a_s});
        n_v2  = (n_v1 >= n_hi) ? n_hi : n_v1;
        n_num = $signed({2'b0, i_cfg.vref}) - n_v2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (i_en) begin
            r_b_v <= r_a_v;
        end
        if (i_en) begin
            r_b_sat <= (n_v2 <= 24'sd0);
            r_b_one <= (n_num <= 24'sd0);
            r_b_vc  <= n_v2[VREF_W-1:0];
            r_b_num <= n_num[VREF_W-1:0];
        end
    end

    // Numerator product balance * (vref - v).
    logic             r_c_v, r_c_sat, r_c_one;
    logic [VREF_W-1:0] r_c_vc;
    logic [NUM_W-1:0]  r_c_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else if (i_en) begin
            r_c_v <= r_b_v;
        end
        if (i_en) begin
            r_c_sat <= r_b_sat;
            r_c_one <= r_b_one;
            r_c_vc  <= r_b_vc;
            r_c_n   <= {{VREF_W{1'b0}}, i_cfg.bal} * {{BAL_W{1'b0}}, r_b_num};
        end
    end

    // Divider pipeline, one quotient bit per stage.
    logic                r_dv_v   [0:DIV_N];
    logic                r_dv_sat [0:DIV_N];
    logic                r_dv_one [0:DIV_N];
    logic [VREF_W-1:0]   r_dv_rem [0:DIV_N];
    logic [VREF_W-1:0]   r_dv_d   [0:DIV_N];
    logic [31:0]         r_dv_n   [0:DIV_N];
    logic [R_W-1:0]      r_dv_q   [0:DIV_N];
    logic                n_big;

    // Quotient at or above 2^48 when v <= N / 2^32.
    assign n_big = ({{(VREF_W-LOW_W){1'b0}}, r_c_n[NUM_W-1:32]} >= r_c_vc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_v[0] <= 1'b0;
        end else if (i_en) begin
            r_dv_v[0] <= r_c_v;
        end
        if (i_en) begin
            r_dv_sat[0] <= r_c_sat || (!r_c_one && n_big);
            r_dv_one[0] <= r_c_one;
            r_dv_rem[0] <= VREF_W'(r_c_n[NUM_W-1:32]);
            r_dv_d[0]   <= r_c_vc;
            r_dv_n[0]   <= r_c_n[31:0];
            r_dv_q[0]   <= '0;
        end
    end

    for (genvar k = 0; k < DIV_N; k++) begin : g_div
        localparam int BIT = DIV_N - 1 - k;
        logic              n_dbit;
        logic [VREF_W:0]   n_shift;
        logic [VREF_W+1:0] n_diff;
        logic              n_ge;
        logic [R_W-1:0]    n_q;

        if (BIT >= R_FRAC_W) begin : g_data
            assign n_dbit = r_dv_n[k][BIT-R_FRAC_W];
        end else begin : g_zero
            assign n_dbit = 1'b0;
        end

        always_comb begin
            n_shift  = {r_dv_rem[k], n_dbit};
            n_diff   = {1'b0, n_shift} - {2'b0, r_dv_d[k]};
            n_ge     = !n_diff[VREF_W+1];
            n_q      = r_dv_q[k];
            n_q[BIT] = n_ge;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_dv_v[k+1] <= r_dv_v[k];
            end
            if (i_en) begin
                r_dv_rem[k+1] <= n_ge ? n_diff[VREF_W-1:0] : n_shift[VREF_W-1:0];
                r_dv_q[k+1]   <= n_q;
                r_dv_d[k+1]   <= r_dv_d[k];
                r_dv_n[k+1]   <= r_dv_n[k];
                r_dv_sat[k+1] <= r_dv_sat[k];
                r_dv_one[k+1] <= r_dv_one[k];
            end
        end
    end

    // Saturation and the one-LSB floor.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_dv_v[DIV_N];
        end
        if (i_en) begin
            if (r_dv_sat[DIV_N]) begin
                o_r <= R_MAX;
            end else if (r_dv_one[DIV_N] || (r_dv_q[DIV_N] == '0)) begin
                o_r <= R_W'(1);
            end else begin
                o_r <= r_dv_q[DIV_N];
            end
        end
    end

endmodule

FILE: sv/ntcsh_recip.sv
// Pipelined reciprocal that turns the Steinhart-Hart sum into saturated millidegrees.
module ntcsh_recip import ntcsh_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  logic signed [S_W-1:0]    i_s,
    output logic                     o_valid,
    output logic signed [TEMP_W-1:0] o_temp
);

    // Magnitude and sign of the sum.
    logic           r_m_v, r_m_neg;
    logic [D_W-1:0] r_m_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_v <= 1'b0;
        end else if (i_en) begin
            r_m_v <= i_valid;
        end
        if (i_en) begin
            r_m_neg <= i_s[S_W-1];
            r_m_d   <= i_s[S_W-1] ? D_W'(-i_s) : D_W'(i_s);
        end
    end

    // Divider pipeline over the constant dividend 1000 * 2^48.
    logic           r_dv_v   [0:TQ_W];
    logic           r_dv_big [0:TQ_W];
    logic           r_dv_neg [0:TQ_W];
    logic [D_W-1:0] r_dv_rem [0:TQ_W];
    logic [D_W-1:0] r_dv_d   [0:TQ_W];
    logic [TQ_W-1:0] r_dv_q  [0:TQ_W];

    // A quotient that does not fit saturates; a zero sum lands here too.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_v[0] <= 1'b0;
        end else if (i_en) begin
            r_dv_v[0] <= r_m_v;
        end
        if (i_en) begin
            r_dv_big[0] <= (r_m_d <= MK_HEAD);
            r_dv_neg[0] <= r_m_neg;
            r_dv_rem[0] <= MK_HEAD;
            r_dv_d[0]   <= r_m_d;
            r_dv_q[0]   <= '0;
        end
    end

    for (genvar k = 0; k < TQ_W; k++) begin : g_div
        localparam int BIT = TQ_W - 1 - k;
        logic [D_W:0]    n_shift;
        logic [D_W+1:0]  n_diff;
        logic            n_ge;
        logic [TQ_W-1:0] n_q;

        always_comb begin
            n_shift  = {r_dv_rem[k], 1'b0};
            n_diff   = {1'b0, n_shift} - {2'b0, r_dv_d[k]};
            n_ge     = !n_diff[D_W+1];
            n_q      = r_dv_q[k];
            n_q[BIT] = n_ge;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_dv_v[k+1] <= r_dv_v[k];
            end
            if (i_en) begin
                r_dv_rem[k+1] <= n_ge ? n_diff[D_W-1:0] : n_shift[D_W-1:0];
                r_dv_q[k+1]   <= n_q;
                r_dv_d[k+1]   <= r_dv_d[k];
                r_dv_big[k+1] <= r_dv_big[k];
                r_dv_neg[k+1] <= r_dv_neg[k];
            end
        end
    end

    // Offset to Celsius, with the rounding fix toward zero for the positive branch.
    logic signed [RES_W-1:0] n_res;
    logic signed [RES_W-1:0] r_f_res;
    logic                    r_f_v, r_f_inc, r_f_big, r_f_neg;

    always_comb begin
        if (r_dv_neg[TQ_W]) begin
            n_res = -$signed({3'b0, r_dv_q[TQ_W]}) - OFFSET_MK;
        end else begin
            n_res = $signed({3'b0, r_dv_q[TQ_W]}) - OFFSET_MK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_v <= 1'b0;
        end else if (i_en) begin
            r_f_v <= r_dv_v[TQ_W];
        end
        if (i_en) begin
            r_f_res <= n_res;
            r_f_inc <= !r_dv_neg[TQ_W] && n_res[RES_W-1] && (r_dv_rem[TQ_W] != '0);
            r_f_big <= r_dv_big[TQ_W];
            r_f_neg <= r_dv_neg[TQ_W];
        end
    end

    // Output register with saturation to the reported range.
    logic signed [RES_W-1:0] n_fix;

    assign n_fix = r_f_res + $signed({{(RES_W-1){1'b0}}, r_f_inc});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_f_v;
        end
        if (i_en) begin
            if (r_f_big) begin
                o_temp <= r_f_neg ? OUT_LOW : OUT_HIGH;
            end else if (n_fix < RES_W'(OUT_LOW)) begin
                o_temp <= OUT_LOW;
            end else if (n_fix > RES_W'(OUT_HIGH)) begin
                o_temp <= OUT_HIGH;
            end else begin
                o_temp <= n_fix[TEMP_W-1:0];
            end
        end
    end

endmodule

FILE: sv/ntc_steinhart_hart_temperature.sv
// Top level of the NTC thermistor temperature block: registers, log, polynomial.
`include "assert_macros.svh"

// Converts one divider voltage sample in microvolts into a temperature in
// millidegrees Celsius by the Steinhart-Hart equation in fixed point. The
// block takes one sample per clock cycle and returns one result per sample,
// in order; the pipeline holds 91 register stages, most of them in the two
// bit-per-stage dividers (48 stages for the thermistor resistance, 21 for
// the final reciprocal). The whole pipeline holds while a finished result is
// not taken. Registers sit on the APB port at byte address 8*i: vref,
// balance resistor, clamp margin, then the A, B and C coefficients in units
// of 2^-48; write them only while the block is idle.
module ntc_steinhart_hart_temperature import ntcsh_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    ntcsh_sample_if.sink          i_sample,
    ntcsh_temp_if.source          o_temp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    // Configuration registers.
    t_cfg r_cfg;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (psel && penable && pwrite) begin
            case (t_reg_idx'(paddr[APB_ADDR_W-1:3]))
                REG_VREF:   r_cfg.vref   <= pwdata[VREF_W-1:0];
                REG_BAL:    r_cfg.bal    <= pwdata[BAL_W-1:0];
                REG_TOL:    r_cfg.tol    <= pwdata[TOL_W-1:0];
                REG_COEF_A: r_cfg.coef_a <= pwdata[COEF_W-1:0];
                REG_COEF_B: r_cfg.coef_b <= pwdata[COEF_W-1:0];
                REG_COEF_C: r_cfg.coef_c <= pwdata[COEF_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (t_reg_idx'(paddr[APB_ADDR_W-1:3]))
            REG_VREF:   prdata = APB_DATA_W'(r_cfg.vref);
            REG_BAL:    prdata = APB_DATA_W'(r_cfg.bal);
            REG_TOL:    prdata = APB_DATA_W'(r_cfg.tol);
            REG_COEF_A: prdata = APB_DATA_W'(r_cfg.coef_a);
            REG_COEF_B: prdata = APB_DATA_W'(r_cfg.coef_b);
            REG_COEF_C: prdata = APB_DATA_W'(r_cfg.coef_c);
            default:    prdata = '0;
        endcase
    end

    // Global advance: the pipeline moves unless the output holds an untaken transaction.
    logic w_en;

    assign w_en           = !o_temp.valid || o_temp.ready;
    assign i_sample.ready = w_en;

    // Resistance in Q32.16 ohms.
    logic           w_r_v;
    logic [R_W-1:0] w_r;

    ntcsh_resist u_resist (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (i_sample.valid),
        .i_sample (i_sample.sample_uv),
        .i_cfg    (r_cfg),
        .o_valid  (w_r_v),
        .o_r      (w_r)
    );

    // Coarse normalize: find the top nonzero byte.
    logic [2:0]     n_cb;
    logic           r_l1_v;
    logic [2:0]     r_l1_cb;
    logic [R_W-1:0] r_l1_x;

    always_comb begin
        n_cb = '0;
        for (int b = 0; b < R_W / 8; b++) begin
            if (w_r[8*b +: 8] != 8'd0) begin
                n_cb = 3'(b);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l1_v <= 1'b0;
        end else if (w_en) begin
            r_l1_v <= w_r_v;
        end
        if (w_en) begin
            r_l1_cb <= n_cb;
            r_l1_x  <= w_r << {3'd5 - n_cb, 3'b000};
        end
    end

    // Fine normalize within the top byte.
    logic [2:0]       n_fb;
    logic [R_W-1:0]   n_x2;
    logic             r_l2_v;
    logic [5:0]       r_l2_p;
    logic [R_W-2:0]   r_l2_frac;

    always_comb begin
        n_fb = '0;
        for (int j = 0; j < 8; j++) begin
            if (r_l1_x[R_W-8+j]) begin
                n_fb = 3'(j);
            end
        end
        n_x2 = r_l1_x << (3'd7 - n_fb);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l2_v <= 1'b0;
        end else if (w_en) begin
            r_l2_v <= r_l1_v;
        end
        if (w_en) begin
            r_l2_p    <= {r_l1_cb, n_fb};
            r_l2_frac <= n_x2[R_W-2:0];
        end
    end

    // Table lookup of the two neighbor entries.
    logic [LOG_IDX_W:0]    n_idx;
    logic                  r_l3_v;
    logic [5:0]            r_l3_p;
    logic [LOG_ENT_W-1:0]  r_l3_lo, r_l3_up;
    logic [LOG_FRAC_W-1:0] r_l3_rem;

    assign n_idx = {1'b0, r_l2_frac[R_W-2 -: LOG_IDX_W]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l3_v <= 1'b0;
        end else if (w_en) begin
            r_l3_v <= r_l2_v;
        end
        if (w_en) begin
            r_l3_p   <= r_l2_p;
            r_l3_lo  <= LOG_TAB[n_idx];
            r_l3_up  <= LOG_TAB[n_idx + 1'b1];
            r_l3_rem <= r_l2_frac[R_W-2-LOG_IDX_W -: LOG_FRAC_W];
        end
    end

    // Interpolation product.
    logic                            r_l4_v;
    logic [5:0]                      r_l4_p;
    logic [LOG_FRAC_W-1:0]           r_l4_lo;
    logic [LOG_ENT_W+LOG_FRAC_W-1:0] r_l4_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l4_v <= 1'b0;
        end else if (w_en) begin
            r_l4_v <= r_l3_v;
        end
        if (w_en) begin
            r_l4_p    <= r_l3_p;
            r_l4_lo   <= r_l3_lo[LOG_FRAC_W-1:0];
            r_l4_prod <= {{LOG_FRAC_W{1'b0}}, r_l3_up - r_l3_lo} *
                         {{LOG_ENT_W{1'b0}}, r_l3_rem};
        end
    end

    // log2 R in Q6.24: exponent minus the sixteen fraction bits, plus the fraction.
    logic [LOG_FRAC_W-1:0]  n_lfrac;
    logic signed [6:0]      n_pm;
    logic                   r_l5_v;
    logic signed [LG_W-1:0] r_l5_lg;

    always_comb begin
        n_lfrac = r_l4_lo + r_l4_prod[LOG_ENT_W+LOG_FRAC_W-2:LOG_FRAC_W];
        n_pm    = $signed({1'b0, r_l4_p}) - 7'sd16;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l5_v <= 1'b0;
        end else if (w_en) begin
            r_l5_v <= r_l4_v;
        end
        if (w_en) begin
            r_l5_lg <= $signed({n_pm[5:0], {LOG_FRAC_W{1'b0}}}) +
                       $signed({6'b0, n_lfrac});
        end
    end

    // Sign and magnitude of log2 R.
    logic             r_l6_v, r_l6_neg;
    logic [ABS_W-1:0] r_l6_abs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l6_v <= 1'b0;
        end else if (w_en) begin
            r_l6_v <= r_l5_v;
        end
        if (w_en) begin
            r_l6_neg <= r_l5_lg[LG_W-1];
            r_l6_abs <= r_l5_lg[LG_W-1] ? ABS_W'(-r_l5_lg) : ABS_W'(r_l5_lg);
        end
    end

    // Natural log magnitude: |log2 R| * ln 2.
    logic                 r_l7_v, r_l7_neg;
    logic [LN_PROD_W-1:0] r_l7_prod;
    logic [ABS_W-1:0]     w_lmag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l7_v <= 1'b0;
        end else if (w_en) begin
            r_l7_v <= r_l6_v;
        end
        if (w_en) begin
            r_l7_neg  <= r_l6_neg;
            r_l7_prod <= {32'b0, r_l6_abs} * {{ABS_W{1'b0}}, LN2_Q32};
        end
    end

    assign w_lmag = r_l7_prod[LN_PROD_W-1:32];

    // Square of ln R and the two halves of B * ln R.
    logic             r_p1_v, r_p1_neg;
    logic [ABS_W-1:0] r_p1_lm;
    logic [SQ_W-1:0]  r_p1_sq;
    logic [48:0]      r_p1_tbl, r_p1_tbh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v <= 1'b0;
        end else if (w_en) begin
            r_p1_v <= r_l7_v;
        end
        if (w_en) begin
            r_p1_neg <= r_l7_neg;
            r_p1_lm  <= w_lmag;
            r_p1_sq  <= {{ABS_W{1'b0}}, w_lmag} * {{ABS_W{1'b0}}, w_lmag};
            r_p1_tbl <= {{ABS_W{1'b0}}, r_cfg.coef_b[19:0]} * {20'b0, w_lmag};
            r_p1_tbh <= {{ABS_W{1'b0}}, r_cfg.coef_b[39:20]} * {20'b0, w_lmag};
        end
    end

    // Cube partial products and the B term.
    logic [68:0]     n_tbfull;
    logic            r_p2_v, r_p2_neg;
    logic [SQ_W-1:0] r_p2_l3a, r_p2_l3b;
    logic [TB_W-1:0] r_p2_tb;

    assign n_tbfull = ({20'b0, r_p1_tbh} << 20) + {20'b0, r_p1_tbl};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_v <= 1'b0;
        end else if (w_en) begin
            r_p2_v <= r_p1_v;
        end
        if (w_en) begin
            r_p2_neg <= r_p1_neg;
            r_p2_l3a <= {{ABS_W{1'b0}}, r_p1_sq[28:0]} * {{ABS_W{1'b0}}, r_p1_lm};
            r_p2_l3b <= {{ABS_W{1'b0}}, r_p1_sq[57:29]} * {{ABS_W{1'b0}}, r_p1_lm};
            r_p2_tb  <= n_tbfull[68:24];
        end
    end

    // ln R cubed in Q.24.
    logic [86:0]     n_l3full;
    logic            r_p3_v, r_p3_neg;
    logic [L3_W-1:0] r_p3_l3;
    logic [TB_W-1:0] r_p3_tb;

    assign n_l3full = ({29'b0, r_p2_l3b} << 29) + {29'b0, r_p2_l3a};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p3_v <= 1'b0;
        end else if (w_en) begin
            r_p3_v <= r_p2_v;
        end
        if (w_en) begin
            r_p3_neg <= r_p2_neg;
            r_p3_l3  <= n_l3full[86:48];
            r_p3_tb  <= r_p2_tb;
        end
    end

    // Four partial products of C * ln R cubed.
    logic            r_p4_v, r_p4_neg;
    logic [TB_W-1:0] r_p4_tb;
    logic [39:0]     r_p4_ll, r_p4_hl;
    logic [38:0]     r_p4_lh, r_p4_hh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p4_v <= 1'b0;
        end else if (w_en) begin
            r_p4_v <= r_p3_v;
        end
        if (w_en) begin
            r_p4_neg <= r_p3_neg;
            r_p4_tb  <= r_p3_tb;
            r_p4_ll  <= {20'b0, r_cfg.coef_c[19:0]} * {20'b0, r_p3_l3[19:0]};
            r_p4_lh  <= {19'b0, r_cfg.coef_c[19:0]} * {20'b0, r_p3_l3[38:20]};
            r_p4_hl  <= {20'b0, r_cfg.coef_c[39:20]} * {20'b0, r_p3_l3[19:0]};
            r_p4_hh  <= {19'b0, r_cfg.coef_c[39:20]} * {20'b0, r_p3_l3[38:20]};
        end
    end

    // C term.
    logic [78:0]     n_tcfull;
    logic            r_p5_v, r_p5_neg;
    logic [TB_W-1:0] r_p5_tb;
    logic [TC_W-1:0] r_p5_tc;

    assign n_tcfull = {39'b0, r_p4_ll} + ({40'b0, r_p4_lh} << 20) +
                      ({39'b0, r_p4_hl} << 20) + ({40'b0, r_p4_hh} << 40);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p5_v <= 1'b0;
        end else if (w_en) begin
            r_p5_v <= r_p4_v;
        end
        if (w_en) begin
            r_p5_neg <= r_p4_neg;
            r_p5_tb  <= r_p4_tb;
            r_p5_tc  <= n_tcfull[78:24];
        end
    end

    // Sum S = A +/- (B term + C term) in units of 2^-48.
    logic [TC_W:0]         n_t;
    logic                  r_p6_v;
    logic signed [S_W-1:0] r_p6_s;

    assign n_t = {11'b0, r_p5_tb} + {1'b0, r_p5_tc};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p6_v <= 1'b0;
        end else if (w_en) begin
            r_p6_v <= r_p5_v;
        end
        if (w_en) begin
            if (r_p5_neg) begin
                r_p6_s <= $signed({18'b0, r_cfg.coef_a}) - $signed({2'b0, n_t});
            end else begin
                r_p6_s <= $signed({18'b0, r_cfg.coef_a}) + $signed({2'b0, n_t});
            end
        end
    end

    // Reciprocal, offset and saturation; its last stage is the output register.
    ntcsh_recip u_recip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_p6_v),
        .i_s     (r_p6_s),
        .o_valid (o_temp.valid),
        .o_temp  (o_temp.temp_milli_c)
    );

    // Every reported temperature lies within the saturation range.
    `ASSERT_CLK(a_temp_range, i_clk, i_rst_n,
        o_temp.valid |-> (o_temp.temp_milli_c >= OUT_LOW && o_temp.temp_milli_c <= OUT_HIGH))
    // The resistance handed to the log stage is never zero.
    `ASSERT_CLK(a_r_nonzero, i_clk, i_rst_n, w_r_v |-> (w_r != '0))
    // A held pipeline keeps its valid bits in place.
    `ASSERT_CLK(a_stall_hold, i_clk, i_rst_n,
        !w_en |=> $stable({r_l1_v, r_l6_v, r_p1_v, r_p6_v}))

endmodule
